// ===== hdl/amm_pkg.sv =====
// Package for the alpha mask multiply block: payload and queue types, register
// map, and the 8-bit scaling function used by the back end.
// No dependencies.
package amm_pkg;

    // Destination area limits; counters are sized from MAX_DIM
    localparam int MAX_DIM = 4096;
    localparam int CNT_W   = $clog2(MAX_DIM);
    localparam int DIM_W   = CNT_W + 1;

    // Request queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int QPTR_W  = $clog2(Q_DEPTH);
    localparam int QCNT_W  = QPTR_W + 1;

    // Register map (byte address 4*index)
    localparam int ADDR_W = 5;
    localparam logic [2:0] REG_RECT_X      = 3'd0;
    localparam logic [2:0] REG_RECT_Y      = 3'd1;
    localparam logic [2:0] REG_RECT_WIDTH  = 3'd2;
    localparam logic [2:0] REG_RECT_HEIGHT = 3'd3;
    localparam logic [2:0] REG_AREA_WIDTH  = 3'd4;
    localparam logic [2:0] REG_AREA_HEIGHT = 3'd5;
    localparam logic [2:0] REG_CLEAR_VALUE = 3'd6;
    localparam logic [2:0] REG_ADD_ALPHA   = 3'd7;

    // Input and result payloads
    typedef struct packed {
        logic [31:0] dest_pixel;
        logic [7:0]  src_alpha;
    } t_amm_in;

    typedef struct packed {
        logic [31:0] pixel_out;
        logic        frame_end;
    } t_amm_out;

    // Configuration register set
    typedef struct packed {
        logic [CNT_W-1:0]  rect_x;
        logic [CNT_W-1:0]  rect_y;
        logic [DIM_W-1:0]  rect_width;
        logic [DIM_W-1:0]  rect_height;
        logic [DIM_W-1:0]  area_width;
        logic [DIM_W-1:0]  area_height;
        logic signed [8:0] clear_value;
        logic              add_alpha_mode;
    } t_amm_cfg;

    // Operation the back end applies to a pixel
    typedef enum logic [1:0] {
        OP_PASS       = 2'd0,
        OP_ALPHA_MUL  = 2'd1,
        OP_ALPHA_SET  = 2'd2,
        OP_ARGB_SCALE = 2'd3
    } t_amm_op;

    // Queue entry: classified request
    typedef struct packed {
        t_amm_op     op;
        logic [7:0]  factor;
        logic [31:0] pixel;
        logic        frame_end;
    } t_amm_req;

    // Queue status toward the top level
    typedef struct packed {
        logic full;
        logic empty;
    } t_amm_qstat;

    // n = c*s; (n + (n >> 7)) >> 8
    function automatic logic [7:0] scale8(input logic [7:0] c, input logic [7:0] s);
        logic [15:0] n;
        logic [16:0] t;
        n = c * s;
        t = {1'b0, n} + {8'd0, n[15:7]};
        return t[15:8];
    endfunction

endpackage

// ===== hdl/amm_cfg.sv =====
// APB register file for the alpha mask multiply block.
// Depends on amm_pkg.
module amm_cfg
    import amm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output t_amm_cfg          o_cfg
);

    t_amm_cfg   r_cfg;
    logic       w_wr;
    logic [2:0] w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign w_idx  = paddr[ADDR_W-1:2];
    assign o_cfg  = r_cfg;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rect_x         <= '0;
            r_cfg.rect_y         <= '0;
            r_cfg.rect_width     <= '0;
            r_cfg.rect_height    <= '0;
            r_cfg.area_width     <= DIM_W'(1);
            r_cfg.area_height    <= DIM_W'(1);
            r_cfg.clear_value    <= -9'sd1;
            r_cfg.add_alpha_mode <= 1'b0;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_RECT_X:      r_cfg.rect_x         <= pwdata[CNT_W-1:0];
                REG_RECT_Y:      r_cfg.rect_y         <= pwdata[CNT_W-1:0];
                REG_RECT_WIDTH:  r_cfg.rect_width     <= pwdata[DIM_W-1:0];
                REG_RECT_HEIGHT: r_cfg.rect_height    <= pwdata[DIM_W-1:0];
                REG_AREA_WIDTH:  r_cfg.area_width     <= pwdata[DIM_W-1:0];
                REG_AREA_HEIGHT: r_cfg.area_height    <= pwdata[DIM_W-1:0];
                REG_CLEAR_VALUE: r_cfg.clear_value    <= pwdata[8:0];
                REG_ADD_ALPHA:   r_cfg.add_alpha_mode <= pwdata[0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        prdata = '0;
        unique case (w_idx)
            REG_RECT_X:      prdata = 32'(r_cfg.rect_x);
            REG_RECT_Y:      prdata = 32'(r_cfg.rect_y);
            REG_RECT_WIDTH:  prdata = 32'(r_cfg.rect_width);
            REG_RECT_HEIGHT: prdata = 32'(r_cfg.rect_height);
            REG_AREA_WIDTH:  prdata = 32'(r_cfg.area_width);
            REG_AREA_HEIGHT: prdata = 32'(r_cfg.area_height);
            REG_CLEAR_VALUE: prdata = {23'd0, r_cfg.clear_value};
            REG_ADD_ALPHA:   prdata = {31'd0, r_cfg.add_alpha_mode};
            default:         prdata = '0;
        endcase
    end

endmodule

// ===== hdl/amm_front.sv =====
// Front end: raster position counters and per-pixel classification into a
// queue request. Depends on amm_pkg.
module amm_front
    import amm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_amm_cfg i_cfg,
    input  t_amm_in  i_data,
    input  logic     i_accept,
    output t_amm_req o_req
);

    logic [CNT_W-1:0]  r_col, r_row;
    logic [CNT_W-1:0]  n_col, n_row;
    logic [DIM_W-1:0]  w_aw, w_ah;
    logic [DIM_W-1:0]  w_col_p1, w_row_p1;
    logic [DIM_W:0]    w_x_end, w_y_end;
    logic              w_last_col, w_last_row, w_inside, w_clr;

    // effective area: zero reads as one, saturate at MAX_DIM
    always_comb begin
        w_aw = i_cfg.area_width;
        if (i_cfg.area_width == '0)
            w_aw = DIM_W'(1);
        else if (i_cfg.area_width > DIM_W'(MAX_DIM))
            w_aw = DIM_W'(MAX_DIM);
        w_ah = i_cfg.area_height;
        if (i_cfg.area_height == '0)
            w_ah = DIM_W'(1);
        else if (i_cfg.area_height > DIM_W'(MAX_DIM))
            w_ah = DIM_W'(MAX_DIM);
    end

    assign w_col_p1   = {1'b0, r_col} + DIM_W'(1);
    assign w_row_p1   = {1'b0, r_row} + DIM_W'(1);
    assign w_last_col = w_col_p1 >= w_aw;
    assign w_last_row = w_row_p1 >= w_ah;

    // rectangle hit test
    assign w_x_end  = {2'b0, i_cfg.rect_x} + {1'b0, i_cfg.rect_width};
    assign w_y_end  = {2'b0, i_cfg.rect_y} + {1'b0, i_cfg.rect_height};
    assign w_inside = (r_col >= i_cfg.rect_x) && ({2'b0, r_col} < w_x_end) &&
                      (r_row >= i_cfg.rect_y) && ({2'b0, r_row} < w_y_end);
    assign w_clr    = ~i_cfg.clear_value[8];

    // classify
    always_comb begin
        o_req.pixel     = i_data.dest_pixel;
        o_req.frame_end = w_last_col & w_last_row;
        o_req.op        = OP_PASS;
        o_req.factor    = i_data.src_alpha;
        if (w_inside) begin
            o_req.op = i_cfg.add_alpha_mode ? OP_ARGB_SCALE : OP_ALPHA_MUL;
        end else if (w_clr) begin
            o_req.factor = i_cfg.clear_value[7:0];
            o_req.op     = i_cfg.add_alpha_mode ? OP_ARGB_SCALE : OP_ALPHA_SET;
        end
    end

    // position advance
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_accept) begin
            if (w_last_col) begin
                n_col = '0;
                n_row = w_last_row ? '0 : w_row_p1[CNT_W-1:0];
            end else begin
                n_col = w_col_p1[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

// ===== hdl/amm_fifo.sv =====
// Short request queue between front and back ends.
// Depends on amm_pkg.
module amm_fifo
    import amm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_amm_req   i_req,
    input  logic       i_pop,
    output t_amm_req   o_req,
    output t_amm_qstat o_stat
);

    t_amm_req          r_mem [Q_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_req        = r_mem[r_rd_ptr];
    assign o_stat.full  = r_count == QCNT_W'(Q_DEPTH);
    assign o_stat.empty = r_count == '0;

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push)
            r_mem[r_wr_ptr] <= i_req;
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push)
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            if (i_pop)
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            if (i_push && !i_pop)
                r_count <= r_count + QCNT_W'(1);
            else if (!i_push && i_pop)
                r_count <= r_count - QCNT_W'(1);
        end
    end

endmodule

// ===== hdl/amm_back.sv =====
// Back end: four-lane 8x8 channel scaling and the output register.
// Depends on amm_pkg.
module amm_back
    import amm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_amm_req i_req,
    input  logic     i_req_valid,
    output logic     o_pop,
    output logic     o_valid,
    input  logic     i_ready,
    output t_amm_out o_data
);

    logic        r_valid;
    t_amm_out    r_data;
    logic [31:0] w_scaled;
    logic [31:0] w_pixel;

    assign o_pop   = i_req_valid & (~r_valid | i_ready);
    assign o_valid = r_valid;
    assign o_data  = r_data;

    // per-channel scale, independent lanes
    always_comb begin
        for (int i = 0; i < 4; i++)
            w_scaled[8*i +: 8] = scale8(i_req.pixel[8*i +: 8], i_req.factor);
    end

    // result select
    always_comb begin
        case (i_req.op)
            OP_PASS:      w_pixel = i_req.pixel;
            OP_ALPHA_MUL: w_pixel = {w_scaled[31:24], i_req.pixel[23:0]};
            OP_ALPHA_SET: w_pixel = {i_req.factor, i_req.pixel[23:0]};
            OP_ARGB_SCALE: begin
                if (i_req.factor == 8'hFF)
                    w_pixel = i_req.pixel;
                else if (i_req.factor == 8'h00)
                    w_pixel = '0;
                else
                    w_pixel = w_scaled;
            end
            default:      w_pixel = i_req.pixel;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data.pixel_out <= w_pixel;
            r_data.frame_end <= i_req.frame_end;
        end
    end

endmodule

// ===== hdl/alpha_mask_multiply_rect_top.sv =====
// Alpha mask multiply over a rectangle: top level. An accepted request goes into
// the queue, then through the back end's four-lane multiply into its output
// register; throughput one pixel per cycle while the output is not stalled.
// Reset (synchronous, active low) clears counters, queue and output valid and
// loads the register defaults. Depends on amm_pkg and all amm_* modules.
module alpha_mask_multiply_rect_top
    import amm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_amm_in           i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_amm_out          o_out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    t_amm_cfg   w_cfg;
    t_amm_req   w_front_req, w_head;
    t_amm_qstat w_qstat;
    logic       w_accept, w_pop;

    assign o_in_ready = ~w_qstat.full;
    assign w_accept   = i_in_valid & o_in_ready;

    amm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    amm_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_data   (i_in_data),
        .i_accept (w_accept),
        .o_req    (w_front_req)
    );

    amm_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_req   (w_front_req),
        .i_pop   (w_pop),
        .o_req   (w_head),
        .o_stat  (w_qstat)
    );

    amm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (w_head),
        .i_req_valid (~w_qstat.empty),
        .o_pop       (w_pop),
        .o_valid     (o_out_valid),
        .i_ready     (i_out_ready),
        .o_data      (o_out_data)
    );

    // queue status is consistent
    a_q_full_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_qstat.full |-> !w_qstat.empty)
        else $error("queue reports full and empty together");

    // a new result only appears after a queued request
    a_out_from_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!w_qstat.empty))
        else $error("result valid without a queued request");

    // reset leaves queue and output empty
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (w_qstat.empty && !o_out_valid))
        else $error("queue or output not empty after reset");

endmodule
